// File: design/hsd_pkg.sv
// Shared types, constants and sizes for the Huffman stream decoder.
package hsd_pkg;

  localparam int MAX_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int SIZE_BITS    = 32;

  localparam int IDX_W  = $clog2(MAX_SYMBOLS);
  localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int CODE_W = MAX_CODE_LEN;
  localparam int SIZE_W = SIZE_BITS;
  localparam int ACC_W  = (SIZE_BITS > MAX_CODE_LEN) ? SIZE_BITS : MAX_CODE_LEN;
  localparam int FLEN_W = $clog2(ACC_W + 1);

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [3:0] {
    PH_HCOUNT, PH_HLEN, PH_WIDTH, PH_SYM, PH_CLEN, PH_CODE,
    PH_DCOUNT, PH_DLEN, PH_DATA, PH_PAD, PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_BIT, S_SETTLE, S_SCAN, S_EMIT, S_NEXT, S_FLUSH
  } bstate_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } q_item_t;

  typedef struct packed {
    logic [7:0]        sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       status;
  } res_t;

endpackage

// File: design/huffman_stream_decoder.sv
// Huffman stream decoder: one compressed byte per input item, bits taken LSB
// first, with the header and code table parsed from the stream and decoded
// symbols (or an error result) returned as output items, run_last marking the
// last one caused by each byte. Bits are handled one at a time. A byte is
// fetched from the queue, its bits are worked through in order, and a final
// flush ends it: an ignored bit (padding or halted) is simply skipped, a
// header bit is added to its field and each field it completes is closed in
// turn, and a data bit extends the prefix, which is checked against the
// entries one per cycle through the single port of the table RAM, stopping
// at the first match; a bit that yields a result passes it on to be held.
// Passing a result on and the final flush can wait on a stalled consumer. A
// two-entry input queue lets the next bytes arrive while one is being worked
// on, and a held result plus an output register let the engine run on while
// the consumer stalls.
module huffman_stream_decoder import hsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic       out_status,
  output logic       out_run_last
);

  logic    q_valid, q_pop;
  q_item_t q_item;

  hsd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte(in_byte), .in_frame_end(in_frame_end),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  hsd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_symbol(out_symbol), .out_status(out_status), .out_run_last(out_run_last)
  );

endmodule

// File: design/hsd_ram.sv
// Generic single-port RAM with registered read.
module hsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: design/hsd_front.sv
// Input side: two-entry queue of compressed bytes ahead of the bit engine.
module hsd_front import hsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_frame_end,
  output logic       q_valid,
  output q_item_t    q_item,
  input  logic       q_pop
);

  q_item_t    slot_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{in_byte: in_byte, frame_end: in_frame_end};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != 2'd0) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_keep_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !q_pop |=> q_valid) else $error("queued item lost");

endmodule

// File: design/hsd_back.sv
// Bit engine: header parse, table load, prefix search and result output.
module hsd_back import hsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  q_item_t    q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic       out_status,
  output logic       out_run_last
);

  bstate_t           state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              fe_r, fe_nxt;
  logic [2:0]        bit_idx_r, bit_idx_nxt;
  logic [ACC_W-1:0]  accum_r, accum_nxt;
  logic [FLEN_W-1:0] flen_r, flen_nxt;
  logic [FLEN_W-1:0] fleft_r, fleft_nxt;
  logic [SIZE_W-1:0] tleft_r, tleft_nxt;
  logic [SIZE_W-1:0] dleft_r, dleft_nxt;
  logic [2:0]        lw_r, lw_nxt;
  logic [7:0]        psym_r, psym_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CODE_W-1:0] ccode_r, ccode_nxt;
  logic [LEN_W-1:0]  clen_r, clen_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              chk_v_r, chk_v_nxt;
  res_t              res_r, res_nxt;
  res_t              hold_r, hold_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic              out_v_r, out_v_nxt;
  res_t              out_r, out_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_addr;
  entry_t            ram_wdata, ram_rdata;
  logic              out_free, cur_bit, hit;
  logic [FLEN_W-1:0] pos;
  logic [10:0]       cnt_bits;
  logic [6:0]        clen_v;

  hsd_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_SYMBOLS)) u_table (
    .clk(clk), .we(ram_we), .re(ram_re), .addr(ram_addr),
    .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign out_valid    = out_v_r;
  assign out_symbol   = out_r.sym;
  assign out_status   = out_r.status;
  assign out_run_last = out_last_r;
  assign out_free     = !out_v_r || !out_stall;
  assign cur_bit      = byte_r[bit_idx_r];
  assign pos          = flen_r - fleft_r;
  assign cnt_bits     = {accum_r[7:0], 3'b000};
  assign clen_v       = accum_r[6:0];
  assign hit          = chk_v_r && (ram_rdata.len == clen_r) && (ram_rdata.code == ccode_r);

  always_comb begin
    state_nxt = state_r;   phase_nxt = phase_r;   byte_nxt = byte_r;
    fe_nxt = fe_r;         bit_idx_nxt = bit_idx_r;
    accum_nxt = accum_r;   flen_nxt = flen_r;     fleft_nxt = fleft_r;
    tleft_nxt = tleft_r;   dleft_nxt = dleft_r;   lw_nxt = lw_r;
    psym_nxt = psym_r;     plen_nxt = plen_r;     count_nxt = count_r;
    ccode_nxt = ccode_r;   clen_nxt = clen_r;     issue_nxt = issue_r;
    chk_v_nxt = chk_v_r;   res_nxt = res_r;       hold_nxt = hold_r;
    hold_v_nxt = hold_v_r; out_nxt = out_r;       out_last_nxt = out_last_r;
    out_v_nxt = out_v_r && out_stall;
    q_pop = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_addr = count_r[IDX_W-1:0];
    ram_wdata = '{sym: psym_r, len: plen_r, code: accum_r[CODE_W-1:0]};

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          byte_nxt = q_item.in_byte;
          fe_nxt = q_item.frame_end;
          bit_idx_nxt = 3'd0;
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        if (phase_r <= PH_DLEN) begin
          accum_nxt = accum_r | (ACC_W'(cur_bit) << pos);
          fleft_nxt = fleft_r - 1'b1;
          if ((phase_r == PH_SYM || phase_r == PH_CLEN || phase_r == PH_CODE)
              && tleft_r != '0) begin
            tleft_nxt = tleft_r - 1'b1;
          end
          state_nxt = S_SETTLE;
        end else if (phase_r == PH_DATA) begin
          ccode_nxt = ccode_r | (CODE_W'(cur_bit) << clen_r);
          clen_nxt = clen_r + 1'b1;
          dleft_nxt = dleft_r - 1'b1;
          issue_nxt = '0;
          chk_v_nxt = 1'b0;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_SETTLE: begin
        if (phase_r <= PH_DLEN && fleft_r == '0) begin
          accum_nxt = '0;
          unique case (phase_r)
            PH_HCOUNT, PH_DCOUNT: begin
              if (cnt_bits > 11'(SIZE_BITS)) begin
                phase_nxt = PH_HALT;
                res_nxt = '{sym: 8'd0, status: STATUS_ERR};
                state_nxt = S_EMIT;
              end else begin
                phase_nxt = (phase_r == PH_HCOUNT) ? PH_HLEN : PH_DLEN;
                flen_nxt = FLEN_W'(cnt_bits);
                fleft_nxt = FLEN_W'(cnt_bits);
              end
            end
            PH_HLEN: begin
              tleft_nxt = accum_r[SIZE_W-1:0];
              phase_nxt = PH_WIDTH;
              flen_nxt = FLEN_W'(3);
              fleft_nxt = FLEN_W'(3);
            end
            PH_WIDTH, PH_CODE: begin
              if (phase_r == PH_CODE && count_r >= CNT_W'(MAX_SYMBOLS)) begin
                phase_nxt = PH_HALT;
                res_nxt = '{sym: 8'd0, status: STATUS_ERR};
                state_nxt = S_EMIT;
              end else begin
                if (phase_r == PH_WIDTH) begin
                  lw_nxt = accum_r[2:0];
                end else begin
                  ram_we = 1'b1;
                  count_nxt = count_r + 1'b1;
                end
                phase_nxt = (tleft_r == '0) ? PH_DCOUNT : PH_SYM;
                flen_nxt = FLEN_W'(8);
                fleft_nxt = FLEN_W'(8);
              end
            end
            PH_SYM: begin
              psym_nxt = accum_r[7:0];
              phase_nxt = PH_CLEN;
              flen_nxt = FLEN_W'(lw_r);
              fleft_nxt = FLEN_W'(lw_r);
            end
            PH_CLEN: begin
              if ({1'b0, clen_v} > 8'(MAX_CODE_LEN)) begin
                phase_nxt = PH_HALT;
                res_nxt = '{sym: 8'd0, status: STATUS_ERR};
                state_nxt = S_EMIT;
              end else begin
                plen_nxt = LEN_W'(clen_v);
                phase_nxt = PH_CODE;
                flen_nxt = FLEN_W'(clen_v);
                fleft_nxt = FLEN_W'(clen_v);
              end
            end
            PH_DLEN: begin
              dleft_nxt = accum_r[SIZE_W-1:0];
              ccode_nxt = '0;
              clen_nxt = '0;
              phase_nxt = (accum_r[SIZE_W-1:0] != '0) ? PH_DATA : PH_PAD;
            end
            default: ;
          endcase
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_SCAN: begin
        // one table entry issued per cycle; compare lags issue by the read latency
        if (hit || (issue_r >= count_r)) begin
          if (hit) begin
            res_nxt = '{sym: ram_rdata.sym, status: STATUS_OK};
            ccode_nxt = '0;
            clen_nxt = '0;
            if (dleft_r == '0) phase_nxt = PH_PAD;
            state_nxt = S_EMIT;
          end else if (clen_r >= LEN_W'(MAX_CODE_LEN)) begin
            res_nxt = '{sym: 8'd0, status: STATUS_ERR};
            phase_nxt = PH_HALT;
            state_nxt = S_EMIT;
          end else begin
            if (dleft_r == '0) phase_nxt = PH_PAD;
            state_nxt = S_NEXT;
          end
          chk_v_nxt = 1'b0;
        end else begin
          ram_re = 1'b1;
          ram_addr = issue_r[IDX_W-1:0];
          issue_nxt = issue_r + 1'b1;
          chk_v_nxt = 1'b1;
        end
      end
      S_EMIT: begin
        // newest result waits in hold until we know whether it ends the byte
        if (!hold_v_r) begin
          hold_nxt = res_r;
          hold_v_nxt = 1'b1;
          state_nxt = S_NEXT;
        end else if (out_free) begin
          out_nxt = hold_r;
          out_last_nxt = 1'b0;
          out_v_nxt = 1'b1;
          hold_nxt = res_r;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (bit_idx_r == 3'd7) begin
          state_nxt = S_FLUSH;
        end else begin
          bit_idx_nxt = bit_idx_r + 1'b1;
          state_nxt = S_BIT;
        end
      end
      S_FLUSH: begin
        if (!hold_v_r || out_free) begin
          if (hold_v_r) begin
            out_nxt = hold_r;
            out_last_nxt = 1'b1;
            out_v_nxt = 1'b1;
            hold_v_nxt = 1'b0;
          end
          if (fe_r) begin
            phase_nxt = PH_HCOUNT;
            accum_nxt = '0;
            flen_nxt = FLEN_W'(8);
            fleft_nxt = FLEN_W'(8);
            tleft_nxt = '0;
            dleft_nxt = '0;
            lw_nxt = '0;
            psym_nxt = '0;
            plen_nxt = '0;
            count_nxt = '0;
            ccode_nxt = '0;
            clen_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;   fe_r <= fe_nxt;       bit_idx_r <= bit_idx_nxt;
    psym_r <= psym_nxt;   plen_r <= plen_nxt;   issue_r <= issue_nxt;
    res_r <= res_nxt;     hold_r <= hold_nxt;   out_r <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_HCOUNT;
      accum_r <= '0;
      flen_r <= FLEN_W'(8);
      fleft_r <= FLEN_W'(8);
      tleft_r <= '0;
      dleft_r <= '0;
      lw_r <= '0;
      count_r <= '0;
      ccode_r <= '0;
      clen_r <= '0;
      chk_v_r <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      flen_r <= flen_nxt;
      fleft_r <= fleft_nxt;
      tleft_r <= tleft_nxt;
      dleft_r <= dleft_nxt;
      lw_r <= lw_nxt;
      count_r <= count_nxt;
      ccode_r <= ccode_nxt;
      clen_r <= clen_nxt;
      chk_v_r <= chk_v_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hold_v_r) else $error("result left in hold at byte end");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SYMBOLS)) else $error("table count overflow");
  a_err_zero_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.status == STATUS_ERR |-> out_r.sym == 8'd0)
    else $error("error result carries a symbol");
  a_prefix_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BIT && phase_r == PH_DATA |-> clen_r < LEN_W'(MAX_CODE_LEN))
    else $error("prefix grew past maximum code length");

endmodule

// File: bench/hsd_checker.sv
// Checker for the Huffman stream decoder: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module hsd_checker import hsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_frame_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_symbol,
  input  logic       out_status,
  input  logic       out_run_last,
  output int         fail_count,
  output int         pending
);

  typedef struct {
    logic [7:0] sym;
    logic       status;
    logic       last;
  } sym_result_t;

  sym_result_t symbols_due[$];

  // predicted decoder state
  phase_t      ph;
  logic [63:0] acc;
  int unsigned bits_left;
  int unsigned fld_len;
  logic [31:0] tbl_left;
  int unsigned width_w;
  logic [31:0] data_left;
  logic [7:0]  hold_sym;
  int unsigned hold_len;
  logic [7:0]  tab_sym [MAX_SYMBOLS];
  int unsigned tab_len [MAX_SYMBOLS];
  logic [63:0] tab_code [MAX_SYMBOLS];
  int unsigned n_entries;
  logic [63:0] prefix;
  int unsigned prefix_len;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic void open_field(phase_t p, int unsigned n);
    ph = p;
    fld_len = n;
    bits_left = n;
    acc = '0;
  endfunction

  function automatic void clear_parser();
    open_field(PH_HCOUNT, 8);
    tbl_left = '0;
    width_w = 0;
    data_left = '0;
    hold_sym = '0;
    hold_len = 0;
    n_entries = 0;
    prefix = '0;
    prefix_len = 0;
  endfunction

  function automatic void next_entry_or_data();
    if (tbl_left == 0) open_field(PH_DCOUNT, 8);
    else open_field(PH_SYM, 8);
  endfunction

  // returns 1 on a header or table error
  function automatic bit close_field();
    int unsigned v;
    unique case (ph)
      PH_HCOUNT, PH_DCOUNT: begin
        v = acc[7:0];
        if (v * 8 > SIZE_BITS) return 1'b1;
        open_field(ph == PH_HCOUNT ? PH_HLEN : PH_DLEN, v * 8);
      end
      PH_HLEN: begin
        tbl_left = acc[31:0];
        open_field(PH_WIDTH, 3);
      end
      PH_WIDTH: begin
        width_w = acc[2:0];
        next_entry_or_data();
      end
      PH_SYM: begin
        hold_sym = acc[7:0];
        open_field(PH_CLEN, width_w);
      end
      PH_CLEN: begin
        v = acc[6:0];
        if (v > MAX_CODE_LEN) return 1'b1;
        hold_len = v;
        open_field(PH_CODE, v);
      end
      PH_CODE: begin
        if (n_entries >= MAX_SYMBOLS) return 1'b1;
        tab_sym[n_entries] = hold_sym;
        tab_len[n_entries] = hold_len;
        tab_code[n_entries] = acc;
        n_entries++;
        next_entry_or_data();
      end
      PH_DLEN: begin
        data_left = acc[31:0];
        prefix = '0;
        prefix_len = 0;
        ph = (data_left != 0) ? PH_DATA : PH_PAD;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic fe);
    sym_result_t found [$];
    sym_result_t r;
    bit err, got;
    logic [7:0] sym;
    int unsigned pos;
    for (int i = 0; i < 8; i++) begin
      err = 0;
      got = 0;
      sym = '0;
      if (ph <= PH_DLEN) begin
        pos = fld_len - bits_left;
        if (pos < 64) acc[pos] = b[i];
        bits_left--;
        if ((ph == PH_SYM || ph == PH_CLEN || ph == PH_CODE) && tbl_left != 0)
          tbl_left--;
        while (!err && ph <= PH_DLEN && bits_left == 0) err = close_field();
      end else if (ph == PH_DATA) begin
        if (prefix_len < 64) prefix[prefix_len] = b[i];
        prefix_len++;
        data_left--;
        for (int k = 0; k < n_entries; k++) begin
          if (tab_len[k] == prefix_len && tab_code[k] == prefix) begin
            got = 1;
            sym = tab_sym[k];
            break;
          end
        end
        if (got) begin
          prefix = '0;
          prefix_len = 0;
        end else if (prefix_len >= MAX_CODE_LEN) begin
          err = 1;
        end
        if (!err && data_left == 0) ph = PH_PAD;
      end
      if (err) begin
        ph = PH_HALT;
        r.sym = '0; r.status = STATUS_ERR; r.last = 0;
        found = {found, r};
      end else if (got) begin
        r.sym = sym; r.status = STATUS_OK; r.last = 0;
        found = {found, r};
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1;
    foreach (found[j]) symbols_due = {symbols_due, found[j]};
    if (fe) clear_parser();
  endfunction

  task automatic report_mismatch(string what, int exp_v, int got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    sym_result_t e;
    if (!rst_n) begin
      clear_parser();
    end else begin
      if (in_valid && !in_stall) predict_byte(in_byte, in_frame_end);
      if (out_valid && !out_stall) begin
        if (symbols_due.size() == 0) begin
          report_mismatch("results outstanding", 0, -1);
        end else begin
          e = symbols_due.pop_front();
          if (out_symbol !== e.sym) report_mismatch("symbol", e.sym, out_symbol);
          if (out_status !== e.status) report_mismatch("status", e.status, out_status);
          if (out_run_last !== e.last) report_mismatch("run_last", e.last, out_run_last);
        end
      end
    end
    pending = symbols_due.size();
  end

endmodule

// File: bench/testbench.sv
// Top of the Huffman stream decoder bench: stimulus, stall patterns and verdict.
`timescale 1ns / 100ps

module testbench import hsd_pkg::*;;

  localparam int IDLE_LIMIT = 60000;
  localparam int TAIL_CYCLES = 3000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_frame_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_symbol;
  logic       out_status;
  logic       out_run_last;
  int         fail_count;
  int         pending;
  int         idle_cycles;
  int         items_sent;
  bit         hold_req;

  bit         msg_bits [$];
  logic [7:0] byte_q [$];
  logic       end_q [$];

  huffman_stream_decoder dut (.*);

  hsd_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_byte, .in_frame_end,
    .out_valid, .out_stall, .out_symbol, .out_status, .out_run_last,
    .fail_count, .pending
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 0;
    out_stall <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_done = 1;
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      out_stall <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  end

  task automatic put_bits(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) msg_bits = {msg_bits, bit'(v[i])};
  endtask

  // packs the bit stream into items, frame_end on the last one
  task automatic pack_frame();
    logic [7:0] b;
    while (msg_bits.size() % 8 != 0 || msg_bits.size() == 0)
      msg_bits = {msg_bits, bit'($urandom_range(0, 1))};
    while (msg_bits.size() > 0) begin
      for (int i = 0; i < 8; i++) b[i] = msg_bits.pop_front();
      byte_q = {byte_q, b};
      end_q = {end_q, logic'(msg_bits.size() == 0)};
    end
  endtask

  task automatic send_item(logic [7:0] b, logic fe);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_frame_end <= fe;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_queued(bit drain);
    while (byte_q.size() > 0) send_item(byte_q.pop_front(), end_q.pop_front());
    if (drain) begin
      in_valid <= 1'b0;
      @(posedge clk);
      wait (pending == 0);
      @(posedge clk);
    end
  endtask

  // drops the last queued item
  task automatic drop_last_item();
    end_q = end_q[0:$-1];
    byte_q = byte_q[0:$-1];
  endtask

  // well-formed message: unary or fixed-length prefix code, then symbols
  task automatic build_message(int n_ent, int w, bit unary, int n_sym, int pad_bits);
    int lens [$];
    logic [63:0] codes [$];
    int max_len, tbits, dbits, w_min, pick;
    max_len = 0;
    tbits = 0;
    dbits = 0;
    for (int j = 0; j < n_ent; j++) begin
      if (unary) begin
        lens = {lens, j + 1};
        codes = {codes, (64'd1 << j) - 64'd1};
      end else begin
        lens = {lens, (n_ent > 1 ? $clog2(n_ent) : 1)};
        codes = {codes, 64'(j)};
      end
      if (lens[j] > max_len) max_len = lens[j];
    end
    w_min = $clog2(max_len + 1);
    if (w < w_min) w = w_min;
    foreach (lens[j]) tbits += 8 + w + lens[j];
    put_bits(2, 8);
    put_bits(tbits, 16);
    put_bits(w, 3);
    foreach (lens[j]) begin
      put_bits($urandom_range(0, 255), 8);
      put_bits(lens[j], w);
      put_bits(codes[j], lens[j]);
    end
    for (int s = 0; s < n_sym; s++) begin
      pick = $urandom_range(0, n_ent - 1);
      codes = {codes, codes[pick]};
      lens = {lens, lens[pick]};
      dbits += lens[pick];
    end
    put_bits(2, 8);
    put_bits(dbits, 16);
    for (int s = n_ent; s < n_ent + n_sym; s++) put_bits(codes[s], lens[s]);
    for (int p = 0; p < pad_bits; p++) msg_bits = {msg_bits, bit'($urandom_range(0, 1))};
    pack_frame();
  endtask

  initial begin
    int n_noise;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_byte <= '0;
    in_frame_end <= 1'b0;
    hold_req = 0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two length-1 codes: eight symbols from one byte
    build_message(2, 1, 0, 24, 0);
    send_queued(1);
    build_message(5, 3, 1, 12, 5);
    send_queued(1);
    // oversized byte count, then ignored bytes while halted
    put_bits(5, 8); put_bits(16'hFFFF, 16);
    pack_frame();
    send_queued(1);
    // zero-length table and data fields
    put_bits(0, 8); put_bits(0, 3); put_bits(0, 8);
    put_bits(8'hFF, 8); put_bits(8'h00, 8);
    pack_frame();
    send_queued(1);
    // code length above the limit
    put_bits(1, 8); put_bits(60, 8); put_bits(6, 3);
    put_bits(8'hA5, 8); put_bits(33, 6);
    pack_frame();
    send_queued(1);
    // duplicate codes and a zero-length code; earliest match wins
    put_bits(1, 8); put_bits(3 * 10 - 1, 8); put_bits(2, 3);
    put_bits(8'h11, 8); put_bits(0, 2);
    put_bits(8'h22, 8); put_bits(1, 2); put_bits(1, 1);
    put_bits(8'h33, 8); put_bits(1, 2); put_bits(1, 1);
    put_bits(1, 8); put_bits(6, 8); put_bits(6'h3F, 6);
    pack_frame();
    send_queued(1);
    // table length shorter than the entry: entry read in full
    put_bits(1, 8); put_bits(5, 8); put_bits(3, 3);
    put_bits(8'h7E, 8); put_bits(2, 3); put_bits(2, 2);
    put_bits(1, 8); put_bits(8, 8); put_bits(8'hFF, 8);
    pack_frame();
    send_queued(1);
    // prefix never matches before the code length limit
    put_bits(1, 8); put_bits(12, 8); put_bits(2, 3);
    put_bits(8'h42, 8); put_bits(2, 2); put_bits(0, 2);
    put_bits(1, 8); put_bits(40, 8); put_bits(40'hFF_FFFF_FFFF, 40);
    pack_frame();
    send_queued(1);
    // message cut short by frame_end at the end of the table length field
    build_message(4, 2, 0, 20, 0);
    while (end_q.size() > 3) drop_last_item();
    end_q[end_q.size()-1] = 1'b1;
    send_queued(1);
    // table overflow: entries of length zero past the maximum count
    put_bits(2, 8); put_bits((MAX_SYMBOLS + 1) * 8, 16); put_bits(0, 3);
    for (int j = 0; j <= MAX_SYMBOLS; j++) put_bits($urandom_range(0, 255), 8);
    pack_frame();
    send_queued(1);

    // random part; the first message runs under a long receiver hold-off
    hold_req = 1;
    build_message(3, 2, 0, 40, 3);
    send_queued(0);
    while (items_sent < 170 + MAX_SYMBOLS + 40) begin
      if ($urandom_range(0, 3) != 0) begin
        build_message($urandom_range(2, 8), $urandom_range(0, 5), $urandom_range(0, 1),
                      $urandom_range(1, 16), $urandom_range(0, 12));
        if ($urandom_range(0, 4) == 0) begin
          while (end_q.size() > 1 && $urandom_range(0, 1)) drop_last_item();
          end_q[end_q.size()-1] = 1'b1;
        end
      end else begin
        n_noise = $urandom_range(1, 6);
        for (int j = 0; j < n_noise; j++) begin
          byte_q = {byte_q, 8'($urandom_range(0, 255))};
          end_q = {end_q, logic'(j == n_noise - 1 || $urandom_range(0, 7) == 0)};
        end
      end
      send_queued($urandom_range(0, 3) == 0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
design/hsd_pkg.sv
design/hsd_ram.sv
design/hsd_front.sv
design/hsd_back.sv
design/huffman_stream_decoder.sv
bench/hsd_checker.sv
bench/testbench.sv
